// ===== rtl/core/crtc_pkg.sv =====
// Shared types, register indexes and codes for the CRT display timing controller.
// No dependencies; every other file in rtl/core imports this package.
package crtc_pkg;

  // Refresh address width and register file size.
  localparam int AddrBits = 14;
  localparam int NumRegs  = 18;
  localparam int ApbAddrW = 3;

  typedef logic [NumRegs-1:0][7:0] crtc_regs_t;

  // Kind of input word.
  localparam logic [1:0] KindTick  = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindRead  = 2'd2;
  localparam logic [1:0] KindPen   = 2'd3;

  // Bus port select.
  localparam logic PortAddr = 1'b0;
  localparam logic PortData = 1'b1;

  // Chip variants; the unused code behaves as the MC type.
  localparam logic [1:0] ChipUm  = 2'd0;
  localparam logic [1:0] ChipUmR = 2'd1;
  localparam logic [1:0] ChipMc  = 2'd2;

  // Cursor blink modes.
  localparam logic [1:0] BlinkOn   = 2'd0;
  localparam logic [1:0] BlinkOff  = 2'd1;
  localparam logic [1:0] BlinkSlow = 2'd2;
  localparam logic [1:0] BlinkFast = 2'd3;

  // Register indexes.
  localparam logic [4:0] RegHTotal     = 5'd0;
  localparam logic [4:0] RegHDisp      = 5'd1;
  localparam logic [4:0] RegHSyncPos   = 5'd2;
  localparam logic [4:0] RegSyncWidth  = 5'd3;
  localparam logic [4:0] RegVTotal     = 5'd4;
  localparam logic [4:0] RegVAdjust    = 5'd5;
  localparam logic [4:0] RegVDisp      = 5'd6;
  localparam logic [4:0] RegVSyncPos   = 5'd7;
  localparam logic [4:0] RegMode       = 5'd8;
  localparam logic [4:0] RegMaxRaster  = 5'd9;
  localparam logic [4:0] RegCurStart   = 5'd10;
  localparam logic [4:0] RegCurEnd     = 5'd11;
  localparam logic [4:0] RegStartHi    = 5'd12;
  localparam logic [4:0] RegStartLo    = 5'd13;
  localparam logic [4:0] RegCurHi      = 5'd14;
  localparam logic [4:0] RegCurLo      = 5'd15;
  localparam logic [4:0] RegPenHi      = 5'd16;
  localparam logic [4:0] RegPenLo      = 5'd17;

  // Configuration register index.
  localparam logic CfgChipType = 1'b0;

  // Status byte bit for vertical blank.
  localparam logic [7:0] StatusVBlank = 8'h20;

  // Display outputs that travel together.
  typedef struct packed {
    logic [AddrBits-1:0] memory_address;
    logic [4:0]          row_address;
    logic                disp_active;
    logic                hsync;
    logic                vsync;
    logic                cursor;
  } crtc_disp_t;

  // Writable bits of each register.
  function automatic logic [7:0] crtc_reg_mask(input logic [4:0] idx);
    logic [7:0] m;
    unique case (idx)
      RegVTotal, RegVDisp, RegVSyncPos, RegCurStart: m = 8'h7F;
      RegVAdjust, RegMaxRaster, RegCurEnd:           m = 8'h1F;
      RegMode:                                       m = 8'hF3;
      RegStartHi, RegCurHi, RegPenHi:                m = 8'h3F;
      default:                                       m = 8'hFF;
    endcase
    return m;
  endfunction

  // Readable registers depend on the variant.
  function automatic logic crtc_can_read(input logic [4:0] idx, input logic [1:0] chip);
    logic ok;
    if (idx > RegPenLo) begin
      ok = 1'b0;
    end else if (chip == ChipUm) begin
      ok = (idx >= RegStartHi);
    end else begin
      ok = (idx >= RegCurHi);
    end
    return ok;
  endfunction

endpackage

// ===== rtl/core/crtc_regfile.sv =====
// Register file, address register and bus read path of the CRT controller.
// Depends on crtc_pkg.
module crtc_regfile (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [1:0]                   kind_i,
  input  logic                         bus_address_i,
  input  logic [7:0]                   write_data_i,
  input  logic [1:0]                   chip_type_i,
  input  logic [crtc_pkg::AddrBits-1:0] refresh_addr_i,
  input  logic                         vde_i,
  output crtc_pkg::crtc_regs_t         regs_o,
  output logic [7:0]                   read_data_o
);
  import crtc_pkg::*;

  crtc_regs_t regs_q;
  logic [4:0] sel_q;
  logic       is_mc;
  logic [7:0] sel_val;

  assign is_mc = (chip_type_i >= ChipMc);

  // Register writes from the bus, light-pen capture of the refresh address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
      sel_q  <= '0;
    end else if (en_i) begin
      if (kind_i == KindWrite) begin
        if (bus_address_i == PortAddr) begin
          sel_q <= write_data_i[4:0];
        end else if (sel_q < RegPenHi) begin
          regs_q[sel_q] <= write_data_i & crtc_reg_mask(sel_q);
        end
      end else if (kind_i == KindPen) begin
        regs_q[RegPenHi] <= {2'b00, refresh_addr_i[AddrBits-1:8]};
        regs_q[RegPenLo] <= refresh_addr_i[7:0];
      end
    end
  end

  // Read of the selected register, or the status byte on the address port.
  always_comb begin
    sel_val = '0;
    if (crtc_can_read(sel_q, chip_type_i)) begin
      sel_val = regs_q[sel_q] & crtc_reg_mask(sel_q);
    end
    read_data_o = '0;
    if (kind_i == KindRead) begin
      if (bus_address_i == PortAddr) begin
        read_data_o = (!is_mc && !vde_i) ? StatusVBlank : 8'h00;
      end else begin
        read_data_o = sel_val;
      end
    end
  end

  assign regs_o = regs_q;

  // Timing registers change only on a bus write word.
  a_regs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en_i && (kind_i == KindWrite)) |=> $stable(regs_q[15:0]))
    else $error("timing registers changed without a bus write");

endmodule

// ===== rtl/core/crtc_timing.sv =====
// Horizontal, raster, row, sync and cursor-blink counters of the CRT controller.
// Depends on crtc_pkg.
module crtc_timing (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic [1:0]                    chip_type_i,
  input  crtc_pkg::crtc_regs_t          regs_i,
  output crtc_pkg::crtc_disp_t          disp_d_o,
  output logic [crtc_pkg::AddrBits-1:0] refresh_addr_o,
  output logic                          vde_o
);
  import crtc_pkg::*;

  logic [7:0]          col_q, col_d;
  logic [4:0]          hsc_q, hsc_d;
  logic [6:0]          row_q, row_d;
  logic [4:0]          raster_q, raster_d;
  logic [4:0]          vsc_q, vsc_d;
  logic                in_adj_q, in_adj_d;
  logic [AddrBits-1:0] ra_q, ra_d;
  logic [AddrBits-1:0] rsa_q, rsa_d;
  logic                hs_q, hs_d, vs_q, vs_d;
  logic                hde_q, hde_d, vde_q, vde_d;
  logic                cursor_q, cursor_d, line_q, line_d;
  logic [4:0]          bc_q, bc_d;
  logic                phase_q, phase_d;

  logic [4:0]          adj;
  logic                has_adj;
  logic [4:0]          last_ras;
  logic                frame_done;
  logic [4:0]          blink_inc;
  logic [4:0]          blink_limit;
  logic [4:0]          hs_w;
  logic [4:0]          vs_w;
  logic [3:0]          vs_nib;
  logic [1:0]          blink_sel;
  logic                blink_pass;
  logic [AddrBits-1:0] cursor_ma;
  logic                is_mc;

  assign is_mc       = (chip_type_i >= ChipMc);
  assign adj         = regs_i[RegVAdjust][4:0];
  assign has_adj     = (adj != 5'd0);
  assign last_ras    = in_adj_q ? (has_adj ? adj - 5'd1 : 5'd0) : regs_i[RegMaxRaster][4:0];
  assign frame_done  = (raster_q == last_ras) &&
                       (in_adj_q || (!has_adj && (row_q == regs_i[RegVTotal][6:0])));
  assign blink_inc   = bc_q + 5'd1;
  assign blink_sel   = regs_i[RegCurStart][6:5];
  assign blink_limit = (blink_sel == BlinkFast) ? 5'd16 : 5'd8;
  assign cursor_ma   = {regs_i[RegCurHi][5:0], regs_i[RegCurLo]};

  // Sync widths per variant.
  assign vs_nib = regs_i[RegSyncWidth][7:4];
  assign hs_w = (is_mc && (regs_i[RegSyncWidth][3:0] == 4'd0)) ?
                5'd16 : {1'b0, regs_i[RegSyncWidth][3:0]};
  assign vs_w = (chip_type_i != ChipUm) ? 5'd16 :
                ((vs_nib == 4'd0) ? 5'd16 : {1'b0, vs_nib});

  // Next state for one character tick.
  always_comb begin
    col_d    = col_q;
    hsc_d    = hsc_q;
    row_d    = row_q;
    raster_d = raster_q;
    vsc_d    = vsc_q;
    in_adj_d = in_adj_q;
    ra_d     = ra_q;
    rsa_d    = rsa_q;
    hs_d     = hs_q;
    vs_d     = vs_q;
    hde_d    = hde_q;
    vde_d    = vde_q;
    cursor_d = cursor_q;
    line_d   = line_q;
    bc_d     = bc_q;
    phase_d  = phase_q;
    blink_pass = 1'b0;

    if (tick_i) begin
      // Character, raster and row counters.
      if (col_q == regs_i[RegHTotal]) begin
        col_d = '0;
        if (frame_done) begin
          raster_d = '0;
          row_d    = '0;
          in_adj_d = 1'b0;
          rsa_d    = {regs_i[RegStartHi][5:0], regs_i[RegStartLo]};
          bc_d     = blink_inc;
          if (blink_inc >= blink_limit) begin
            bc_d    = '0;
            phase_d = !phase_q;
          end
        end else if (!in_adj_q && (raster_q == last_ras)) begin
          raster_d = '0;
          rsa_d    = rsa_q + {6'b0, regs_i[RegHDisp]};
          row_d    = row_q + 7'd1;
          if ((row_d == regs_i[RegVTotal][6:0]) && has_adj) begin
            in_adj_d = 1'b1;
          end
        end else begin
          raster_d = raster_q + 5'd1;
        end
        ra_d = rsa_d;
      end else begin
        col_d = col_q + 8'd1;
        ra_d  = ra_q + 14'd1;
      end

      hde_d = (col_d < regs_i[RegHDisp]);
      vde_d = (row_d < regs_i[RegVDisp][6:0]);

      // Horizontal sync.
      if (hs_q) begin
        if (hsc_q >= hs_w) begin
          hs_d  = 1'b0;
          hsc_d = '0;
        end else begin
          hsc_d = hsc_q + 5'd1;
        end
      end else if (col_d == regs_i[RegHSyncPos]) begin
        hs_d  = 1'b1;
        hsc_d = 5'd1;
      end

      // Vertical sync, counted in lines at the hsync position.
      if (col_d == regs_i[RegHSyncPos]) begin
        if (!vs_q && (row_d == regs_i[RegVSyncPos][6:0]) && (raster_d == 5'd0)) begin
          vs_d  = 1'b1;
          vsc_d = '0;
        end else if (vs_q) begin
          vsc_d = vsc_q + 5'd1;
          if (vsc_d == vs_w) begin
            vs_d = 1'b0;
          end
        end
      end

      // Cursor line window and blink.
      if (hde_d && vde_d && (ra_d == cursor_ma)) begin
        unique case (blink_sel)
          BlinkOn:  blink_pass = 1'b1;
          BlinkOff: blink_pass = 1'b0;
          default:  blink_pass = phase_d;
        endcase
        if (raster_d == 5'd0) begin
          line_d = 1'b0;
        end
        if (raster_d == regs_i[RegCurStart][4:0]) begin
          line_d = 1'b1;
        end
        cursor_d = line_d && blink_pass;
        if (raster_d == regs_i[RegCurEnd][4:0]) begin
          line_d = 1'b0;
        end
      end else begin
        cursor_d = 1'b0;
      end
    end
  end

  // Counter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      hsc_q    <= '0;
      row_q    <= '0;
      raster_q <= '0;
      vsc_q    <= '0;
      in_adj_q <= 1'b0;
      ra_q     <= '0;
      rsa_q    <= '0;
      hs_q     <= 1'b0;
      vs_q     <= 1'b0;
      hde_q    <= 1'b0;
      vde_q    <= 1'b0;
      cursor_q <= 1'b0;
      line_q   <= 1'b0;
      bc_q     <= '0;
      phase_q  <= 1'b1;
    end else begin
      col_q    <= col_d;
      hsc_q    <= hsc_d;
      row_q    <= row_d;
      raster_q <= raster_d;
      vsc_q    <= vsc_d;
      in_adj_q <= in_adj_d;
      ra_q     <= ra_d;
      rsa_q    <= rsa_d;
      hs_q     <= hs_d;
      vs_q     <= vs_d;
      hde_q    <= hde_d;
      vde_q    <= vde_d;
      cursor_q <= cursor_d;
      line_q   <= line_d;
      bc_q     <= bc_d;
      phase_q  <= phase_d;
    end
  end

  // Outputs as they stand after the current word.
  always_comb begin
    disp_d_o.memory_address = ra_d;
    disp_d_o.row_address    = raster_d;
    disp_d_o.disp_active    = hde_d && vde_d;
    disp_d_o.hsync          = hs_d;
    disp_d_o.vsync          = vs_d;
    disp_d_o.cursor         = cursor_d;
  end

  assign refresh_addr_o = ra_q;
  assign vde_o          = vde_q;

  // Counters advance only on character ticks.
  a_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_i |=> $stable(col_q) && $stable(raster_q) && $stable(row_q) && $stable(ra_q))
    else $error("counters moved without a character tick");

  // Horizontal sync count stays within the widest sync.
  a_hs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs_q |-> (hsc_q <= 5'd16))
    else $error("hsync count past maximum width");

  // Cursor shows only inside the display area.
  a_cursor_de: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q |-> (hde_q && vde_q))
    else $error("cursor outside display area");

endmodule

// ===== rtl/core/crt_display_timing_controller.sv =====
// Top level of the CRT display timing controller: input stage, result register, APB port.
// A word passes from the input stage to the result register, which holds its result word.
// Throughput: one word per cycle when the result slot is free; one regfile and counter pass.
// Reset: asynchronous, active low; clears all counters, the register file and valid flags,
// sets the chip type to the MC variant and the blink phase to on.
// Depends on crtc_pkg, crtc_regfile and crtc_timing.
module crt_display_timing_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic                          bus_address_i,
  input  logic [7:0]                    write_data_i,
  // Result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    read_data_o,
  output logic [crtc_pkg::AddrBits-1:0] memory_address_o,
  output logic [4:0]                    row_address_o,
  output logic                          disp_active_o,
  output logic                          hsync_o,
  output logic                          vsync_o,
  output logic                          cursor_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crtc_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import crtc_pkg::*;

  logic                in_valid_q;
  logic [1:0]          kind_q;
  logic                bus_address_q;
  logic [7:0]          write_data_q;
  logic                out_valid_q;
  logic [7:0]          read_data_q;
  crtc_disp_t          disp_q;
  logic                adv;
  logic [1:0]          chip_type_q;
  crtc_regs_t          regs;
  logic [7:0]          read_data;
  crtc_disp_t          disp_d;
  logic [AddrBits-1:0] refresh_addr;
  logic                vde;

  // Pipeline moves when the input stage holds a word and the result slot is free.
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q        <= kind_i;
      bus_address_q <= bus_address_i;
      write_data_q  <= write_data_i;
    end
  end

  // Configuration register and APB read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_type_q <= ChipMc;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CfgChipType)) begin
      chip_type_q <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CfgChipType) ? {30'b0, chip_type_q} : 32'b0;

  crtc_regfile u_regfile (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .kind_i         (kind_q),
    .bus_address_i  (bus_address_q),
    .write_data_i   (write_data_q),
    .chip_type_i    (chip_type_q),
    .refresh_addr_i (refresh_addr),
    .vde_i          (vde),
    .regs_o         (regs),
    .read_data_o    (read_data)
  );

  crtc_timing u_timing (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (adv && (kind_q == KindTick)),
    .chip_type_i    (chip_type_q),
    .regs_i         (regs),
    .disp_d_o       (disp_d),
    .refresh_addr_o (refresh_addr),
    .vde_o          (vde)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      read_data_q <= read_data;
      disp_q      <= disp_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = read_data_q;
  assign memory_address_o = disp_q.memory_address;
  assign row_address_o    = disp_q.row_address;
  assign disp_active_o    = disp_q.disp_active;
  assign hsync_o          = disp_q.hsync;
  assign vsync_o          = disp_q.vsync;
  assign cursor_o         = disp_q.cursor;

endmodule
